// ----- hdl/cvh_pkg.sv -----
// Shared types, widths and helper functions of the convex hull block.
`default_nettype none

package cvh_pkg;

  // Default depth of the point store.
  localparam int MAX_POINTS_DEF = 1024;

  // Coordinate and arithmetic widths.
  localparam int COORD_W = 16;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int AREA_W  = PROD_W + 1;
  localparam int FRAC_W  = 32;
  localparam int D2_W    = PROD_W;
  localparam int RAD_W   = D2_W + FRAC_W;
  localparam int ROOT_W  = RAD_W / 2;
  localparam int REM_W   = ROOT_W + 2;

  // Result field widths.
  localparam int HULL_W  = 11;
  localparam int PERIM_W = 34;
  localparam int TAREA_W = 33;

  // One input item.
  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic                      last;
  } in_t;

  // One result item.
  typedef struct packed {
    logic [HULL_W-1:0]  hull_count;
    logic [PERIM_W-1:0] perimeter_q16;
    logic [TAREA_W-1:0] twice_area;
  } out_t;

  // Request for one hull edge from point a to point b.
  typedef struct packed {
    logic                      vld;
    logic signed [COORD_W-1:0] ax;
    logic signed [COORD_W-1:0] ay;
    logic signed [COORD_W-1:0] bx;
    logic signed [COORD_W-1:0] by;
  } edge_req_t;

  // Per-edge contributions coming back from the edge unit.
  typedef struct packed {
    logic                     area_vld;
    logic signed [PROD_W-1:0] area_term;
    logic                     len_vld;
    logic [ROOT_W-1:0]        len;
    logic                     busy;
  } edge_res_t;

  // Data handed from one square root cell to the next.
  typedef struct packed {
    logic              vld;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [RAD_W-1:0]  rad;
  } sq_stage_t;

  // Difference of two coordinates, one bit wider.
  function automatic logic signed [DIFF_W-1:0] coord_sub(
    input logic signed [COORD_W-1:0] a,
    input logic signed [COORD_W-1:0] b
  );
    coord_sub = DIFF_W'(a) - DIFF_W'(b);
  endfunction

  // Sum of two coordinates, one bit wider.
  function automatic logic signed [DIFF_W-1:0] coord_add(
    input logic signed [COORD_W-1:0] a,
    input logic signed [COORD_W-1:0] b
  );
    coord_add = DIFF_W'(a) + DIFF_W'(b);
  endfunction

endpackage

`default_nettype wire

// ----- hdl/cvh_sqrt_cell.sv -----
// One digit cell of the pipelined integer square root chain.
`default_nettype none

module cvh_sqrt_cell (
  input  wire                 clk,
  input  wire                 rst_n,
  input  cvh_pkg::sq_stage_t  stg_in,
  output cvh_pkg::sq_stage_t  stg_out
);

  logic [cvh_pkg::REM_W-1:0]  rem_sh;
  logic [cvh_pkg::REM_W-1:0]  trial;
  logic                       ge;
  logic                       vld_r;
  logic [cvh_pkg::REM_W-1:0]  rem_r;
  logic [cvh_pkg::ROOT_W-1:0] root_r;
  logic [cvh_pkg::RAD_W-1:0]  rad_r;

  // Bring down the next two radicand bits and try the next root digit.
  always_comb begin
    rem_sh = {stg_in.rem[cvh_pkg::REM_W-3:0], stg_in.rad[cvh_pkg::RAD_W-1 -: 2]};
    trial  = {stg_in.root, 2'b01};
    ge     = (rem_sh >= trial);
  end

  // The valid bit is control and is reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= stg_in.vld;
    end
  end

  // The digit data moves on to the neighbor every cycle.
  always_ff @(posedge clk) begin
    rem_r  <= ge ? (rem_sh - trial) : rem_sh;
    root_r <= {stg_in.root[cvh_pkg::ROOT_W-2:0], ge};
    rad_r  <= {stg_in.rad[cvh_pkg::RAD_W-3:0], 2'b00};
  end

  assign stg_out = '{vld: vld_r, rem: rem_r, root: root_r, rad: rad_r};

endmodule

`default_nettype wire

// ----- hdl/cvh_edge_unit.sv -----
// Edge unit: edge length in Q16 through a chain of root cells, and the shoelace term.
`default_nettype none

module cvh_edge_unit (
  input  wire                 clk,
  input  wire                 rst_n,
  input  cvh_pkg::edge_req_t  req,
  output cvh_pkg::edge_res_t  res
);

  localparam int NCELL = cvh_pkg::ROOT_W;

  logic                            v1_r, v2_r, v3_r;
  logic signed [cvh_pkg::DIFF_W-1:0] dx_r, dy_r, sy_r;
  logic signed [cvh_pkg::PROD_W-1:0] dxx_r, dyy_r, at_r;
  logic [cvh_pkg::D2_W-1:0]        d2_r;
  cvh_pkg::sq_stage_t              stg [NCELL+1];
  logic [NCELL:0]                  cvld;

  // Valid bits of the three arithmetic stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= req.vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // Differences, then products, then the squared length.
  always_ff @(posedge clk) begin
    dx_r  <= cvh_pkg::coord_sub(req.ax, req.bx);
    dy_r  <= cvh_pkg::coord_sub(req.ay, req.by);
    sy_r  <= cvh_pkg::coord_add(req.ay, req.by);
    dxx_r <= dx_r * dx_r;
    dyy_r <= dy_r * dy_r;
    at_r  <= dx_r * sy_r;
    d2_r  <= $unsigned(dxx_r) + $unsigned(dyy_r);
  end

  // The squared length, scaled by 2^32, enters the root chain.
  assign stg[0] = '{vld: v3_r, rem: '0, root: '0,
                    rad: {d2_r, {cvh_pkg::FRAC_W{1'b0}}}};

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    cvh_sqrt_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .stg_in  (stg[i]),
      .stg_out (stg[i+1])
    );
  end

  for (genvar i = 0; i <= NCELL; i++) begin : g_vld
    assign cvld[i] = stg[i].vld;
  end

  // Contributions back to the accumulators.
  assign res.area_vld  = v2_r;
  assign res.area_term = at_r;
  assign res.len_vld   = stg[NCELL].vld;
  assign res.len       = stg[NCELL].root;
  assign res.busy      = v1_r | v2_r | (|cvld);

endmodule

`default_nettype wire

// ----- hdl/convex_hull_perimeter_area.sv -----
// Top level: point store, gift wrapping walk and result accumulation.
//
// Usage. Points enter on in_data while start is high and busy is low, one item
// per cycle while loading. The item with last set ends the set and starts the
// hull walk; busy stays high until the result is out. The result appears on
// out_data for exactly one cycle with out_valid high; the receiver cannot
// stall it. After a result the block is empty and takes a new set.
// Points beyond MAX_POINTS are dropped; their last bit still starts the walk.
// Walk. The walk visits candidates in arrival order, one memory read per
// cycle: an unvisited candidate is fetched and checked, then every stored
// point is read for its side test through the product pipeline, followed
// by the final flag check and the decision; a visited one is only fetched
// and checked. Sweeps repeat until one adds no vertex. The closing edge
// then passes through the square root chain before the result strobe.
// The single read port of the point store sets the pace of the walk.
// Reset. Synchronous active-low reset empties the store and clears the walk;
// the visited flags need no clearing pass, each is written when its point is.
`default_nettype none

module convex_hull_perimeter_area #(
  parameter int MAX_POINTS = cvh_pkg::MAX_POINTS_DEF
) (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            start,
  output logic           busy,
  input  cvh_pkg::in_t   in_data,
  output logic           out_valid,
  output cvh_pkg::out_t  out_data
);

  localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int CW_ = cvh_pkg::COORD_W;

  typedef enum logic [7:0] {
    S_LOAD  = 8'b0000_0001,
    S_INIT  = 8'b0000_0010,
    S_CRD   = 8'b0000_0100,
    S_CCHK  = 8'b0000_1000,
    S_SCAN  = 8'b0001_0000,
    S_DEC   = 8'b0010_0000,
    S_CLOSE = 8'b0100_0000,
    S_DRAIN = 8'b1000_0000
  } state_t;

  // Point store and visited flags.
  logic [CW_-1:0] px_mem [MAX_POINTS];
  logic [CW_-1:0] py_mem [MAX_POINTS];
  logic           vis_mem [MAX_POINTS];

  state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] j_r, j_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic [CW-1:0] hull_r, hull_nxt;
  logic [IW-1:0] min_idx_r, min_idx_nxt;
  logic signed [CW_-1:0] min_x_r, min_x_nxt, min_y_r, min_y_nxt;
  logic signed [CW_-1:0] tx_r, tx_nxt, ty_r, ty_nxt;
  logic signed [CW_-1:0] cx_r, cx_nxt, cy_r, cy_nxt;
  logic signed [cvh_pkg::DIFF_W-1:0] ex_r, ex_nxt, ey_r, ey_nxt;
  logic added_r, added_nxt, pos_r, pos_nxt, neg_r, neg_nxt;
  logic sv1_r, sv1_nxt, sv2_r, sv3_r;
  logic signed [cvh_pkg::AREA_W-1:0] area_r, area_nxt;
  logic [cvh_pkg::PERIM_W-1:0] perim_r, perim_nxt;
  logic out_valid_r, out_valid_nxt;
  cvh_pkg::out_t out_data_r, out_data_nxt;

  logic signed [CW_-1:0] rd_x_r, rd_y_r;
  logic rd_v_r;
  logic signed [cvh_pkg::DIFF_W-1:0] dxk_r, dyk_r;
  logic signed [cvh_pkg::PROD_W-1:0] p1_r, p2_r;
  logic signed [cvh_pkg::PROD_W:0] side_cr;

  logic [IW-1:0] rd_addr;
  logic ld_we, vis_we, vis_wd, accept, last_j, add_now;
  logic [IW-1:0] vis_addr;
  logic signed [cvh_pkg::AREA_W-1:0] area_abs;
  cvh_pkg::edge_req_t ereq;
  cvh_pkg::edge_res_t eres;

  assign accept = start && !busy;
  assign busy   = (state_r != S_LOAD);
  assign side_cr = (cvh_pkg::PROD_W+1)'(p1_r) - (cvh_pkg::PROD_W+1)'(p2_r);
  assign area_abs = area_r[cvh_pkg::AREA_W-1] ? -area_r : area_r;

  // Store writes and the registered read port.
  always_ff @(posedge clk) begin
    if (ld_we) begin
      px_mem[count_r[IW-1:0]] <= in_data.x;
      py_mem[count_r[IW-1:0]] <= in_data.y;
    end
    if (vis_we) begin
      vis_mem[vis_addr] <= vis_wd;
    end
    rd_x_r <= $signed(px_mem[rd_addr]);
    rd_y_r <= $signed(py_mem[rd_addr]);
    rd_v_r <= vis_mem[rd_addr];
  end

  // Side test pipeline: offsets from the tail, then the two cross products.
  always_ff @(posedge clk) begin
    dxk_r <= cvh_pkg::coord_sub(rd_x_r, tx_r);
    dyk_r <= cvh_pkg::coord_sub(rd_y_r, ty_r);
    p1_r  <= ex_r * dyk_r;
    p2_r  <= ey_r * dxk_r;
  end

  cvh_edge_unit u_edge (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (ereq),
    .res   (eres)
  );

  // Walk sequencer and accumulators.
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    hull_nxt      = hull_r;
    min_idx_nxt   = min_idx_r;
    min_x_nxt     = min_x_r;
    min_y_nxt     = min_y_r;
    tx_nxt        = tx_r;
    ty_nxt        = ty_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    ex_nxt        = ex_r;
    ey_nxt        = ey_r;
    added_nxt     = added_r;
    pos_nxt       = pos_r;
    neg_nxt       = neg_r;
    sv1_nxt       = 1'b0;
    area_nxt      = area_r;
    perim_nxt     = perim_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    rd_addr       = j_r[IW-1:0];
    ld_we         = 1'b0;
    vis_we        = 1'b0;
    vis_wd        = 1'b0;
    vis_addr      = count_r[IW-1:0];
    add_now       = 1'b0;
    ereq          = '{vld: 1'b0, ax: tx_r, ay: ty_r, bx: cx_r, by: cy_r};
    last_j        = ((j_r + CW'(1)) == count_r);

    // Collect edge contributions as they come out.
    if (eres.area_vld) begin
      area_nxt = area_nxt + cvh_pkg::AREA_W'(eres.area_term);
    end
    if (eres.len_vld) begin
      perim_nxt = perim_nxt + cvh_pkg::PERIM_W'(eres.len);
    end

    // A cross product leaving the pipeline updates the side flags.
    if (sv3_r) begin
      if (side_cr > 0) pos_nxt = 1'b1;
      if (side_cr < 0) neg_nxt = 1'b1;
    end

    case (state_r)
      S_LOAD: begin
        if (accept) begin
          if (count_r < CW'(MAX_POINTS)) begin
            ld_we  = 1'b1;
            vis_we = 1'b1;
            count_nxt = count_r + CW'(1);
            if (count_r == '0 || in_data.y < min_y_r) begin
              min_idx_nxt = count_r[IW-1:0];
              min_x_nxt   = in_data.x;
              min_y_nxt   = in_data.y;
            end
          end
          if (in_data.last) begin
            state_nxt = S_INIT;
          end
        end
      end
      S_INIT: begin
        vis_we    = 1'b1;
        vis_wd    = 1'b1;
        vis_addr  = min_idx_r;
        tx_nxt    = min_x_r;
        ty_nxt    = min_y_r;
        hull_nxt  = CW'(1);
        j_nxt     = '0;
        added_nxt = 1'b0;
        state_nxt = S_CRD;
      end
      S_CRD: begin
        state_nxt = S_CCHK;
      end
      S_CCHK: begin
        if (!rd_v_r) begin
          cx_nxt    = rd_x_r;
          cy_nxt    = rd_y_r;
          ex_nxt    = cvh_pkg::coord_sub(rd_x_r, tx_r);
          ey_nxt    = cvh_pkg::coord_sub(rd_y_r, ty_r);
          pos_nxt   = 1'b0;
          neg_nxt   = 1'b0;
          k_nxt     = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (k_r != count_r) begin
          rd_addr = k_r[IW-1:0];
          sv1_nxt = 1'b1;
          k_nxt   = k_r + CW'(1);
        end else if (!sv1_r && !sv2_r && !sv3_r) begin
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (!(pos_r && neg_r)) begin
          add_now  = 1'b1;
          ereq.vld = 1'b1;
          vis_we   = 1'b1;
          vis_wd   = 1'b1;
          vis_addr = j_r[IW-1:0];
          tx_nxt   = cx_r;
          ty_nxt   = cy_r;
          hull_nxt = hull_r + CW'(1);
        end
      end
      S_CLOSE: begin
        ereq      = '{vld: 1'b1, ax: tx_r, ay: ty_r, bx: min_x_r, by: min_y_r};
        state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        if (!eres.busy) begin
          out_valid_nxt = 1'b1;
          out_data_nxt.hull_count    = cvh_pkg::HULL_W'(hull_r);
          out_data_nxt.perimeter_q16 = perim_r;
          out_data_nxt.twice_area    = area_abs[cvh_pkg::TAREA_W-1:0];
          count_nxt = '0;
          area_nxt  = '0;
          perim_nxt = '0;
          state_nxt = S_LOAD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase

    // Move to the next candidate, or start another pass, or close the hull.
    if ((state_r == S_CCHK && rd_v_r) || state_r == S_DEC) begin
      if (!last_j) begin
        j_nxt     = j_r + CW'(1);
        added_nxt = added_r | add_now;
        state_nxt = S_CRD;
      end else if (added_r || add_now) begin
        j_nxt     = '0;
        added_nxt = 1'b0;
        state_nxt = S_CRD;
      end else begin
        state_nxt = S_CLOSE;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      count_r     <= '0;
      j_r         <= '0;
      k_r         <= '0;
      hull_r      <= '0;
      added_r     <= 1'b0;
      pos_r       <= 1'b0;
      neg_r       <= 1'b0;
      sv1_r       <= 1'b0;
      sv2_r       <= 1'b0;
      sv3_r       <= 1'b0;
      area_r      <= '0;
      perim_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      j_r         <= j_nxt;
      k_r         <= k_nxt;
      hull_r      <= hull_nxt;
      added_r     <= added_nxt;
      pos_r       <= pos_nxt;
      neg_r       <= neg_nxt;
      sv1_r       <= sv1_nxt;
      sv2_r       <= sv1_r;
      sv3_r       <= sv2_r;
      area_r      <= area_nxt;
      perim_r     <= perim_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Coordinate and result registers.
  always_ff @(posedge clk) begin
    min_idx_r  <= min_idx_nxt;
    min_x_r    <= min_x_nxt;
    min_y_r    <= min_y_nxt;
    tx_r       <= tx_nxt;
    ty_r       <= ty_nxt;
    cx_r       <= cx_nxt;
    cy_r       <= cy_nxt;
    ex_r       <= ex_nxt;
    ey_r       <= ey_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The store never holds more points than it has room for.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_POINTS))
    else $error("point count above store depth");

  // A result only follows a drained edge unit.
  a_out_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == S_DRAIN))
    else $error("result without drain");

  // The result strobe lasts one cycle.
  a_out_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe longer than one cycle");

  // The candidate edge holds during its side test.
  a_edge_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && $past(state_r == S_SCAN)) |-> ($stable(ex_r) && $stable(ey_r)))
    else $error("candidate edge changed during scan");

  // The hull never has more vertices than stored points.
  a_hull_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_LOAD && state_r != S_INIT) |-> (hull_r <= count_r))
    else $error("hull count above point count");

endmodule

`default_nettype wire
